FILE: design/atmpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package atmpc_pkg;
  // Input operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CALPT  = 1'b1;

  // Datapath commands issued by the controller
  typedef struct packed {
    logic load;        // capture request, write history
    logic hist_rd;     // read one history entry (addr from counter)
    logic hist_cap;    // capture returned history word into window
    logic sort_step;   // one odd/even compare-exchange pass
    logic mean;        // form trimmed mean
    logic cal_rd;      // read calibration point
    logic cal_cap;     // capture calibration word
    logic seg_eval;    // evaluate segment at current index
    logic div_start;   // set up the divider
    logic div_step;    // one quotient bit
    logic finish;      // form the result
  } atmpc_cmd_t;

  typedef struct packed {
    logic seg_hit;     // segment found or extrapolation chosen
    logic seg_zero;    // result is zero, no division
    logic div_done;
  } atmpc_sts_t;
endpackage
`default_nettype wire

FILE: design/atmpc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface atmpc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [2:0]  channel;
  logic [23:0] sample;
  logic [3:0]  point_index;
  logic [23:0] point_value;
  modport source (output valid, operation, channel, sample, point_index, point_value,
                  input ready);
  modport sink   (input valid, operation, channel, sample, point_index, point_value,
                  output ready);
endinterface

interface atmpc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_channel;
  logic [23:0] filtered_value;
  logic [31:0] calibrated_value;
  modport source (output valid, out_channel, filtered_value, calibrated_value,
                  input ready);
  modport sink   (input valid, out_channel, filtered_value, calibrated_value,
                  output ready);
endinterface

interface atmpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: design/atmpc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module atmpc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/atmpc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module atmpc_ctrl #(
  parameter int WINDOW_SIZE = 7,
  parameter int CAL_POINTS  = 11
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,      // sample request accepted
  input  wire atmpc_pkg::atmpc_sts_t sts,
  input  wire logic                  out_taken,
  output atmpc_pkg::atmpc_cmd_t      cmd,
  output logic [$clog2(WINDOW_SIZE+1)-1:0] win_cnt,
  output logic [$clog2(CAL_POINTS+1)-1:0]  seg_cnt,
  output logic                       busy,
  output logic                       out_valid
);
  import atmpc_pkg::*;

  localparam int WCW = $clog2(WINDOW_SIZE + 1);
  localparam int SCW = $clog2(CAL_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_HRD, S_HCAP, S_SORT, S_MEAN, S_CRD0, S_CCAP0, S_CCAP1, S_EVAL,
    S_DSTART, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t         state_r;
  logic [WCW-1:0] win_cnt_r;
  logic [SCW-1:0] seg_cnt_r;

  assign win_cnt   = win_cnt_r;
  assign seg_cnt   = seg_cnt_r;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // Command decode
  always_comb begin
    cmd = '0;
    cmd.load      = (state_r == S_IDLE) && start;
    cmd.hist_rd   = (state_r == S_HRD);
    cmd.hist_cap  = (state_r == S_HCAP);
    cmd.sort_step = (state_r == S_SORT);
    cmd.mean      = (state_r == S_MEAN);
    cmd.cal_rd    = (state_r == S_CRD0) || (state_r == S_CCAP0);
    cmd.cal_cap   = (state_r == S_CCAP0) || (state_r == S_CCAP1);
    cmd.seg_eval  = (state_r == S_EVAL);
    cmd.div_start = (state_r == S_DSTART);
    cmd.div_step  = (state_r == S_DIV);
    cmd.finish    = (state_r == S_FIN);
  end

  // Sequencer: history fetch, sort passes, segment scan, divide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      win_cnt_r <= '0;
      seg_cnt_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r   <= S_HRD;
            win_cnt_r <= '0;
          end
        end
        S_HRD: state_r <= S_HCAP;
        S_HCAP: begin
          if (win_cnt_r == WCW'(WINDOW_SIZE - 1)) begin
            state_r   <= S_SORT;
            win_cnt_r <= '0;
          end else begin
            win_cnt_r <= win_cnt_r + 1'b1;
            state_r   <= S_HRD;
          end
        end
        S_SORT: begin
          if (win_cnt_r == WCW'(WINDOW_SIZE - 1)) begin
            state_r <= S_MEAN;
          end else begin
            win_cnt_r <= win_cnt_r + 1'b1;
          end
        end
        S_MEAN: begin
          state_r   <= S_CRD0;
          seg_cnt_r <= '0;
        end
        // Read cal[k] then cal[k+1]
        S_CRD0:  state_r <= S_CCAP0;
        S_CCAP0: state_r <= S_CCAP1;
        S_CCAP1: state_r <= S_EVAL;
        S_EVAL: begin
          if (sts.seg_zero) begin
            state_r <= S_FIN;
          end else if (sts.seg_hit) begin
            state_r <= S_DSTART;
          end else begin
            seg_cnt_r <= seg_cnt_r + 1'b1;
            state_r   <= S_CRD0;
          end
        end
        S_DSTART: state_r <= S_DIV;
        S_DIV: begin
          if (sts.div_done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: state_r <= S_OUT;
        S_OUT: begin
          if (out_taken) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: design/atmpc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module atmpc_dp #(
  parameter int CHANNELS      = 8,
  parameter int HISTORY_DEPTH = 8,
  parameter int WINDOW_SIZE   = 7,
  parameter int CAL_POINTS    = 11,
  parameter int SAMPLE_BITS   = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire atmpc_pkg::atmpc_cmd_t cmd,
  input  wire logic [$clog2(WINDOW_SIZE+1)-1:0] win_cnt,
  input  wire logic [$clog2(CAL_POINTS+1)-1:0]  seg_cnt,
  input  wire logic                  cal_we,
  input  wire logic [2:0]            in_channel,
  input  wire logic [23:0]           in_sample,
  input  wire logic [3:0]            in_point_index,
  input  wire logic [23:0]           in_point_value,
  input  wire logic [23:0]           span,
  output atmpc_pkg::atmpc_sts_t      sts,
  output logic [2:0]                 res_channel,
  output logic [23:0]                res_filtered,
  output logic [31:0]                res_calibrated
);
  import atmpc_pkg::*;

  localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HDW  = $clog2(HISTORY_DEPTH);
  localparam int WCW  = $clog2(WINDOW_SIZE + 1);
  localparam int SCW  = $clog2(CAL_POINTS + 1);
  localparam int HD   = CHANNELS * HISTORY_DEPTH;
  localparam int HAW  = $clog2(HD);
  localparam int CD   = CHANNELS * CAL_POINTS;
  localparam int CAW  = $clog2(CD);
  localparam int LO   = (WINDOW_SIZE - 3) / 2;
  localparam int LAST = CAL_POINTS - 2;
  localparam int NW   = 24 + SAMPLE_BITS;   // span * num width
  localparam int RW   = 24 + SCW;           // span * k width

  // Request capture and per-channel slot
  logic [CHW-1:0]         ch_r;
  logic [HDW-1:0]         slot_r [CHANNELS];
  logic [HDW-1:0]         pos_r;
  logic [CHANNELS*HISTORY_DEPTH-1:0] hvalid_r;
  logic [HAW-1:0]         hw_addr;
  logic [HAW-1:0]         hr_addr;
  logic [SAMPLE_BITS-1:0] h_rdata;
  logic [SAMPLE_BITS-1:0] newest;
  logic [HAW-1:0]         hr_addr_r;

  assign newest  = SAMPLE_BITS'(in_sample);
  assign hw_addr = HAW'(in_channel) * HAW'(HISTORY_DEPTH) +
                   HAW'(slot_r[in_channel[CHW-1:0]]);
  assign hr_addr = HAW'(ch_r) * HAW'(HISTORY_DEPTH) + HAW'(pos_r);

  atmpc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HD)) u_hist (
    .clk  (clk),
    .we   (cmd.load),
    .waddr(hw_addr),
    .wdata(newest),
    .raddr(hr_addr),
    .rdata(h_rdata)
  );

  // Slots, entry valid bits, window walk position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        slot_r[i] <= '0;
      end
      hvalid_r <= '0;
    end else if (cmd.load) begin
      hvalid_r[hw_addr] <= 1'b1;
      slot_r[in_channel[CHW-1:0]] <=
        (slot_r[in_channel[CHW-1:0]] == HDW'(HISTORY_DEPTH - 1)) ? '0 :
        slot_r[in_channel[CHW-1:0]] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r  <= in_channel[CHW-1:0];
      pos_r <= slot_r[in_channel[CHW-1:0]];
    end else if (cmd.hist_rd) begin
      hr_addr_r <= hr_addr;
      pos_r     <= (pos_r == '0) ? HDW'(HISTORY_DEPTH - 1) : pos_r - 1'b1;
    end
  end

  // Sort window: odd/even transposition, one pass per cycle
  logic [SAMPLE_BITS-1:0] win_r [WINDOW_SIZE];
  always_ff @(posedge clk) begin
    if (cmd.hist_cap) begin
      win_r[win_cnt[WCW-1:0]] <= hvalid_r[hr_addr_r] ? h_rdata : '0;
    end else if (cmd.sort_step) begin
      for (int j = 0; j + 1 < WINDOW_SIZE; j++) begin
        if ((j % 2) == int'(win_cnt[0])) begin
          if (win_r[j] > win_r[j+1]) begin
            win_r[j]   <= win_r[j+1];
            win_r[j+1] <= win_r[j];
          end
        end
      end
    end
  end

  // Trimmed mean: divide by 3 through reciprocal multiply (rounded down) and correction
  logic [SAMPLE_BITS+1:0] sum3;
  logic [SAMPLE_BITS+1:0] q0;
  logic [SAMPLE_BITS+1:0] rem3;
  logic [SAMPLE_BITS-1:0] filt;
  logic [2*SAMPLE_BITS+3:0] prod3;
  assign sum3  = (SAMPLE_BITS+2)'(win_r[LO]) + (SAMPLE_BITS+2)'(win_r[LO+1]) +
                 (SAMPLE_BITS+2)'(win_r[LO+2]);
  assign prod3 = (2*SAMPLE_BITS+4)'(sum3) *
                 (2*SAMPLE_BITS+4)'(((64'd1 << (SAMPLE_BITS+2)) - 64'd1) / 64'd3);
  assign q0    = prod3[2*SAMPLE_BITS+3:SAMPLE_BITS+2];
  assign rem3  = sum3 - q0 * (SAMPLE_BITS+2)'(3);
  assign filt  = SAMPLE_BITS'((rem3 >= (SAMPLE_BITS+2)'(3)) ? q0 + 1'b1 : q0);

  logic [SAMPLE_BITS-1:0] v_r;
  always_ff @(posedge clk) begin
    if (cmd.mean) begin
      v_r <= filt;
    end
  end

  // Calibration point store, undefined until written
  logic [CAW-1:0] cw_addr;
  logic [CAW-1:0] cr_addr;
  logic [23:0]    c_rdata;
  logic [SCW-1:0] cidx;
  assign cw_addr = CAW'(in_channel) * CAW'(CAL_POINTS) + CAW'(in_point_index);
  assign cidx    = (cmd.cal_cap) ? seg_cnt + 1'b1 : seg_cnt;
  assign cr_addr = CAW'(ch_r) * CAW'(CAL_POINTS) + CAW'(cidx);

  atmpc_ram #(.WIDTH(24), .DEPTH(CD)) u_cal (
    .clk  (clk),
    .we   (cal_we),
    .waddr(cw_addr),
    .wdata(in_point_value),
    .raddr(cr_addr),
    .rdata(c_rdata)
  );

  logic [23:0] ca_r, cb_r;
  logic        cb_sel_r;
  always_ff @(posedge clk) begin
    if (cmd.cal_rd && !cmd.cal_cap) begin
      cb_sel_r <= 1'b0;
    end else if (cmd.cal_cap) begin
      cb_sel_r <= 1'b1;
      if (!cb_sel_r) begin
        ca_r <= c_rdata;
      end else begin
        cb_r <= c_rdata;
      end
    end
  end

  // Segment evaluation on widened values (SAMPLE_BITS may exceed 24)
  logic [32:0] vv, ca, cb;
  logic        in_seg, at_last;
  assign vv      = 33'(v_r);
  assign ca      = 33'(ca_r);
  assign cb      = 33'(cb_r);
  assign in_seg  = (vv > ca) && (vv <= cb);
  assign at_last = (seg_cnt == SCW'(LAST));

  logic        zero_now;
  always_comb begin
    zero_now = 1'b0;
    if (seg_cnt == '0 && vv <= ca) begin
      zero_now = 1'b1;
    end else if (at_last && !(vv > ca)) begin
      zero_now = 1'b1;
    end
  end
  assign sts.seg_zero = zero_now;
  assign sts.seg_hit  = in_seg || at_last;

  // Divider: restoring, one quotient bit per cycle
  logic [NW-1:0]    num_r;     // span * num
  logic [32:0]      den_r;
  logic [NW-1:0]    quo_r;
  logic [33:0]      rem_r;
  logic [$clog2(NW+1)-1:0] dcnt_r;
  logic             rising_r;
  logic [RW-1:0]    base_r;
  logic             zero_r;
  logic [SAMPLE_BITS-1:0] dnum;
  logic [34:0]      rem_sh;

  assign dnum   = (seg_cnt == '0) ? v_r : SAMPLE_BITS'(vv - ca);
  assign rem_sh = {rem_r, num_r[NW-1]};
  assign sts.div_done = (dcnt_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.seg_eval) begin
      zero_r   <= zero_now;
      base_r   <= RW'(span) * RW'(seg_cnt);
      rising_r <= cb > ca;
      den_r    <= cb - ca;
      num_r    <= NW'(span) * NW'(dnum);
    end else if (cmd.div_start) begin
      rem_r  <= '0;
      quo_r  <= '0;
      dcnt_r <= ($clog2(NW+1))'(NW);
      if (!rising_r) begin
        num_r <= '0;
        dcnt_r <= '0;
      end
    end else if (cmd.div_step && dcnt_r != '0) begin
      num_r  <= num_r << 1;
      dcnt_r <= dcnt_r - 1'b1;
      if (rem_sh >= 35'(den_r)) begin
        rem_r <= 34'(rem_sh - 35'(den_r));
        quo_r <= {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[33:0];
        quo_r <= {quo_r[NW-2:0], 1'b0};
      end
    end
  end

  // Result with saturation
  logic [NW:0] total;
  assign total = (NW+1)'(base_r) + (rising_r ? (NW+1)'(quo_r) : '0);
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_channel    <= 3'(ch_r);
      res_filtered   <= 24'(v_r);
      if (zero_r) begin
        res_calibrated <= '0;
      end else if (total > (NW+1)'(33'h0_FFFF_FFFF)) begin
        res_calibrated <= '1;
      end else begin
        res_calibrated <= 32'(total);
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/adc_trimmed_median_piecewise_calibration_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Payload
// in_     | in  | operation, channel, sample, point_index, point_value
// out_    | out | out_channel, filtered_value, calibrated_value
// cfg_    | in  | data = segment_span
// After a sample is accepted, out_valid rises once the block has made WINDOW_SIZE history
// reads and captures, run WINDOW_SIZE sort passes, formed the mean, scanned 1 to CAL_POINTS-1
// calibration segments, run the divider on a rising segment (set up only on a flat one,
// skipped for a zero result) and formed the result. Synchronous active-low reset clears
// history and slots and sets span to 500000; calibration points are undefined until
// written. in_ready stays low until the result is taken on out_ready.
module adc_trimmed_median_piecewise_calibration_top #(
  parameter int CHANNELS      = 8,
  parameter int HISTORY_DEPTH = 8,
  parameter int WINDOW_SIZE   = 7,
  parameter int CAL_POINTS    = 11,
  parameter int SAMPLE_BITS   = 24
) (
  input wire logic clk,
  input wire logic rst_n,
  atmpc_in_if.sink    in_ch,
  atmpc_out_if.source out_ch,
  atmpc_cfg_if.sink   cfg_ch
);
  import atmpc_pkg::*;

  localparam int WCW = $clog2(WINDOW_SIZE + 1);
  localparam int SCW = $clog2(CAL_POINTS + 1);

  atmpc_cmd_t     cmd;
  atmpc_sts_t     sts;
  logic [WCW-1:0] win_cnt;
  logic [SCW-1:0] seg_cnt;
  logic           busy;
  logic           acc;
  logic           ch_ok;
  logic           start;
  logic           cal_we;
  logic [23:0]    span_r;

  assign in_ch.ready = !busy;
  assign acc    = in_ch.valid && in_ch.ready;
  assign ch_ok  = (32'(in_ch.channel) < CHANNELS);
  assign start  = acc && ch_ok && (in_ch.operation == OP_SAMPLE);
  assign cal_we = acc && ch_ok && (in_ch.operation == OP_CALPT) &&
                  (32'(in_ch.point_index) < CAL_POINTS);

  // Span register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= 24'd500000;
    end else if (cfg_ch.valid) begin
      span_r <= cfg_ch.data;
    end
  end

  atmpc_ctrl #(.WINDOW_SIZE(WINDOW_SIZE), .CAL_POINTS(CAL_POINTS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .sts      (sts),
    .out_taken(out_ch.ready),
    .cmd      (cmd),
    .win_cnt  (win_cnt),
    .seg_cnt  (seg_cnt),
    .busy     (busy),
    .out_valid(out_ch.valid)
  );

  atmpc_dp #(
    .CHANNELS(CHANNELS), .HISTORY_DEPTH(HISTORY_DEPTH), .WINDOW_SIZE(WINDOW_SIZE),
    .CAL_POINTS(CAL_POINTS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .win_cnt       (win_cnt),
    .seg_cnt       (seg_cnt),
    .cal_we        (cal_we),
    .in_channel    (in_ch.channel),
    .in_sample     (in_ch.sample),
    .in_point_index(in_ch.point_index),
    .in_point_value(in_ch.point_value),
    .span          (span_r),
    .sts           (sts),
    .res_channel   (out_ch.out_channel),
    .res_filtered  (out_ch.filtered_value),
    .res_calibrated(out_ch.calibrated_value)
  );
endmodule
`default_nettype wire

FILE: tb/adc_trimmed_median_piecewise_calibration_top_test.sv
`timescale 1ns / 1ps
module adc_trimmed_median_piecewise_calibration_top_test;
  import atmpc_pkg::*;

  localparam int NCH = 8;
  localparam int HDEPTH = 8;
  localparam int WIN = 7;
  localparam int NPTS = 11;
  localparam logic [23:0] SPAN_AT_RESET = 24'd500000;

  logic clk;
  logic rst_n;

  atmpc_in_if  in_ch();
  atmpc_out_if out_ch();
  atmpc_cfg_if cfg_ch();

  adc_trimmed_median_piecewise_calibration_top uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  typedef struct packed {
    logic [2:0]  chan;
    logic [23:0] filt;
    logic [31:0] calv;
  } reading_t;

  // shadow state of the block
  logic [23:0] span;
  logic [23:0] hist [NCH][HDEPTH];
  logic [2:0]  slot [NCH];
  logic [23:0] cal [NCH][NPTS];
  bit          cal_known [NCH][NPTS];

  reading_t readings_due[$];
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  // trimmed mean of the seven newest samples after pushing a new one
  function automatic logic [23:0] push_and_filter(input int ch, input logic [23:0] smp);
    logic [23:0] w [WIN];
    logic [23:0] t;
    logic [25:0] sum;
    int p;
    p = slot[ch];
    hist[ch][p] = smp;
    for (int i = 0; i < WIN; i++) begin
      w[i] = hist[ch][p];
      p = (p == 0) ? HDEPTH - 1 : p - 1;
    end
    slot[ch] = slot[ch] + 3'd1;
    for (int i = 0; i < WIN - 1; i++) begin
      for (int j = 0; j < WIN - 1 - i; j++) begin
        if (w[j] > w[j + 1]) begin
          t = w[j];
          w[j] = w[j + 1];
          w[j + 1] = t;
        end
      end
    end
    sum = w[2] + w[3] + w[4];
    return 24'(sum / 3);
  endfunction

  // piecewise-linear mapping through the channel's points
  function automatic logic [31:0] calibrate_reading(input int ch, input logic [23:0] v);
    int k;
    bit hit;
    logic [63:0] res;
    logic [63:0] num;
    hit = 0;
    k = 0;
    if (v <= cal[ch][0]) return 32'd0;
    for (int i = 0; i < NPTS - 2; i++) begin
      if (!hit && v > cal[ch][i] && v <= cal[ch][i + 1]) begin
        hit = 1;
        k = i;
      end
    end
    if (!hit) begin
      if (v > cal[ch][NPTS - 2]) k = NPTS - 2;
      else return 32'd0;
    end
    res = 64'(span) * k;
    if (cal[ch][k + 1] > cal[ch][k]) begin
      num = (k == 0) ? 64'(v) : 64'(v - cal[ch][k]);
      res += (64'(span) * num) / 64'(cal[ch][k + 1] - cal[ch][k]);
    end
    if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
    return res[31:0];
  endfunction

  function automatic bool_all_known(input int ch);
    for (int i = 0; i < NPTS; i++) if (!cal_known[ch][i]) return 0;
    return 1;
  endfunction

  // send one request; predict the reading for samples
  task automatic send_request(input logic op, input logic [2:0] ch, input logic [23:0] smp,
                              input logic [3:0] pidx, input logic [23:0] pval,
                              input bit fixed, input logic [31:0] fixed_cal);
    reading_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.channel <= ch;
    in_ch.sample <= smp;
    in_ch.point_index <= pidx;
    in_ch.point_value <= pval;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_CALPT) begin
      if (pidx < NPTS) begin
        cal[ch][pidx] = pval;
        cal_known[ch][pidx] = 1;
      end
    end else begin
      r.chan = ch;
      r.filt = push_and_filter(ch, smp);
      r.calv = calibrate_reading(ch, r.filt);
      if (fixed && r.calv != fixed_cal) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row: expected %0d, predicted %0d", fixed_cal, r.calv);
      end
      readings_due.push_back(r);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_span(input logic [23:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    span = val;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    reading_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_channel, out_ch.filtered_value, out_ch.calibrated_value};
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reading %h", got);
      end else begin
        want = readings_due.pop_front();
        if (got.chan !== want.chan || got.filt !== want.filt || got.calv !== want.calv) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reading mismatch: expected ch %0d filt %0d cal %0d, got ch %0d filt %0d cal %0d",
                     want.chan, want.filt, want.calv, got.chan, got.filt, got.calv);
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // random calibration table for one channel, rising or disordered
  task automatic load_points(input int ch, input bit ordered);
    logic [23:0] base;
    base = $urandom_range(20000);
    for (int p = 0; p < NPTS; p++) begin
      if (ordered) base = base + $urandom_range(1600000, 1);
      else base = $urandom_range(24'hFFFFFF);
      send_request(OP_CALPT, ch, $urandom, p, base, 0, 0);
    end
  endtask

  typedef struct {
    logic op; logic [2:0] ch; logic [23:0] smp; logic [3:0] pidx; logic [23:0] pval;
    bit fixed; logic [31:0] calv;
  } row_t;

  row_t rows[$];

  initial begin
    int ch;
    int n;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_SAMPLE;
    in_ch.channel = '0;
    in_ch.sample = '0;
    in_ch.point_index = '0;
    in_ch.point_value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    span = SPAN_AT_RESET;
    for (int c = 0; c < NCH; c++) begin
      slot[c] = '0;
      for (int i = 0; i < HDEPTH; i++) hist[c][i] = '0;
      for (int i = 0; i < NPTS; i++) begin
        cal[c][i] = '0;
        cal_known[c][i] = 0;
      end
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: channel 0 points at 0,1M..10M; channel 7 points all equal max
    for (int p = 0; p < NPTS; p++)
      rows.push_back('{OP_CALPT, 3'd0, 24'hFFFFFF, p, 24'(p * 1000000), 0, 0});
    for (int p = 0; p < NPTS; p++)
      rows.push_back('{OP_CALPT, 3'd7, 24'd0, p, 24'hFFFFFF, 0, 0});
    rows.push_back('{OP_CALPT, 3'd0, 24'd0, 4'd15, 24'h123456, 0, 0}); // index out of range
    rows.push_back('{OP_SAMPLE, 3'd0, 24'hFFFFFF, 4'hF, 24'hFFFFFF, 1, 0}); // trimmed mean still zero
    rows.push_back('{OP_SAMPLE, 3'd7, 24'hFFFFFF, 4'd0, 24'd0, 1, 0});
    foreach (rows[i])
      send_request(rows[i].op, rows[i].ch, rows[i].smp, rows[i].pidx, rows[i].pval,
                   rows[i].fixed, rows[i].calv);
    // fill channel 0 to reach extrapolation
    repeat (7) send_request(OP_SAMPLE, 3'd0, 24'hFFFFFF, 0, 0, 0, 0);
    send_request(OP_SAMPLE, 3'd0, 24'd1500000, 0, 0, 0, 0);
    wait_drained();
    write_span(24'hFFFFFF);
    repeat (4) send_request(OP_SAMPLE, 3'd0, 24'd2500000, 0, 0, 0, 0);
    wait_drained();
    write_span(24'd1);
    repeat (3) send_request(OP_SAMPLE, 3'd0, 24'd0, 0, 0, 0, 0);

    // random phases: set up channels (every channel in the first phase), then mostly samples
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      write_span(ph == 0 ? 24'd500000 : 24'($urandom_range(24'hFFFFFF, 1)));
      for (int c = 0; c < NCH; c++)
        if (ph == 0 || $urandom_range(3) == 0) load_points(c, $urandom_range(4) != 0);
      n = 0;
      while (n < 120) begin
        ch = $urandom_range(NCH - 1);
        if ($urandom_range(19) == 0)
          send_request(OP_CALPT, ch, $urandom, $urandom_range(15), $urandom, 0, 0);
        else begin
          send_request(OP_SAMPLE, ch,
                       ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(17000000)),
                       $urandom, $urandom, 0, 0);
          n++;
        end
      end
    end
    wait_drained();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
